[design/expression_lexer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the expression lexer
// Shared concurrent check forms; clk and rst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_LEXER_MACROS_SVH
`define EXPRESSION_LEXER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define EL_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("expression_lexer: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define EL_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("expression_lexer: next-cycle check failed");

`endif

[design/el_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// el_pkg
// Field widths, token kind codes and defaults for the expression lexer.
// ----------------------------------------------------------------------------
package el_pkg;

  localparam int CHAR_W            = 8;
  localparam int KIND_W            = 4;
  localparam int FIELD_W           = 16;  // width of token_start / token_length
  localparam int OFFSET_WIDTH_DEF  = 16;

  // token kinds
  localparam logic [KIND_W-1:0] TK_SEMI   = 4'd0;
  localparam logic [KIND_W-1:0] TK_NUM    = 4'd1;
  localparam logic [KIND_W-1:0] TK_STR    = 4'd2;
  localparam logic [KIND_W-1:0] TK_LBRACE = 4'd3;
  localparam logic [KIND_W-1:0] TK_RBRACE = 4'd4;
  localparam logic [KIND_W-1:0] TK_ADD    = 4'd5;
  localparam logic [KIND_W-1:0] TK_MUL    = 4'd6;
  localparam logic [KIND_W-1:0] TK_LPAREN = 4'd7;
  localparam logic [KIND_W-1:0] TK_RPAREN = 4'd8;
  localparam logic [KIND_W-1:0] TK_ERR    = 4'd9;
  localparam logic [KIND_W-1:0] TK_END    = 4'd10;

endpackage

[design/el_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// el_in_if
// Source byte channel: valid/ready handshake carrying one byte per request.
// ----------------------------------------------------------------------------
interface el_in_if;
  import el_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              final_char;

  modport source (output valid, char_code, final_char, input ready);
  modport sink   (input valid, char_code, final_char, output ready);
endinterface

[design/el_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// el_out_if
// Token channel: valid/ready handshake carrying one token per request.
// ----------------------------------------------------------------------------
interface el_out_if;
  import el_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [FIELD_W-1:0] token_start;
  logic [FIELD_W-1:0] token_length;
  logic               run_last;

  modport source (output valid, token_kind, token_start, token_length, run_last,
                  input ready);
  modport sink   (input valid, token_kind, token_start, token_length, run_last,
                  output ready);
endinterface

[design/expression_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming tokenizer: source bytes in, (kind, start, length) tokens out.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per request on in_chan and returns tokens on
// out_chan, each tagged run_last on the final token caused by that byte. A
// byte first lands in an input register; once the result register is free, a
// small decoder runs the scan mode update and writes every token that byte
// causes (up to three) into the result register, from which they leave one
// per cycle while out_chan is ready, and so the lexer runs at one byte per
// cycle for bytes that yield zero or one token; a byte that yields k tokens
// holds the result register until all k have left. The first token of a byte
// is valid on out_chan once the byte moves from the input register into the
// result register. The input register can take one more byte while results
// still wait downstream. Offsets and lengths are OFFSET_WIDTH bits inside and
// saturate at all ones; the ports show their low 16 bits. After an error token
// or the end token the lexer swallows every byte without result until reset.
// ----------------------------------------------------------------------------
module expression_lexer #(
  parameter int OFFSET_WIDTH = el_pkg::OFFSET_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  el_in_if.sink     in_chan,
  el_out_if.source  out_chan
);
  import el_pkg::*;

  `include "expression_lexer_macros.svh"

  localparam int OW = OFFSET_WIDTH;
  localparam logic [OW-1:0] OFF_MAX = {OW{1'b1}};
  localparam logic [OW-1:0] OFF_ONE = OW'(1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  localparam int NCAND = 4;  // flush, single-byte token, final flush, end
  localparam int NSLOT = 3;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_DQ, M_SQ, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_HALT
  } mode_t;

  function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] v);
    return (v == OFF_MAX) ? v : v + OFF_ONE;
  endfunction

  // input register
  logic              inv_r;
  logic [CHAR_W-1:0] ch_r;
  logic              fin_r;

  // scan state
  mode_t         mode_r, mode_nxt;
  logic [OW-1:0] pos_r, pos_nxt;
  logic [OW-1:0] pst_r, pst_nxt;
  logic [OW-1:0] plen_r, plen_nxt;

  // result register: up to three tokens, drained by idx_r
  logic [KIND_W-1:0] bk_r [NSLOT];
  logic [OW-1:0]     bs_r [NSLOT];
  logic [OW-1:0]     bl_r [NSLOT];
  logic [1:0]        cnt_r;
  logic [1:0]        idx_r;

  // candidate tokens in emit order
  logic              cand_en [NCAND];
  logic [KIND_W-1:0] cand_k  [NCAND];
  logic [OW-1:0]     cand_s  [NCAND];
  logic [OW-1:0]     cand_l  [NCAND];

  logic [KIND_W-1:0] slot_k [NSLOT];
  logic [OW-1:0]     slot_s [NSLOT];
  logic [OW-1:0]     slot_l [NSLOT];
  logic [1:0]        res_n;

  logic out_fire, out_last, batch_free, adv, in_fire;
  logic is_dig, is_space, do_idle;
  logic [OW-1:0] plen_inc;

  // ------------------------------------------------------------------------
  // handshake
  // ------------------------------------------------------------------------
  assign out_fire   = out_chan.valid && out_chan.ready;
  assign out_last   = (idx_r == cnt_r - 2'd1);
  assign batch_free = (cnt_r == 2'd0) || (out_fire && out_last);
  assign adv        = inv_r && batch_free;       // byte moves into decode
  assign in_chan.ready = !inv_r || adv;
  assign in_fire    = in_chan.valid && in_chan.ready;

  assign out_chan.valid        = (cnt_r != 2'd0);
  assign out_chan.token_kind   = bk_r[idx_r];
  assign out_chan.token_start  = FIELD_W'(bs_r[idx_r]);
  assign out_chan.token_length = FIELD_W'(bl_r[idx_r]);
  assign out_chan.run_last     = out_last;

  // ------------------------------------------------------------------------
  // byte decode and mode update
  // ------------------------------------------------------------------------
  assign is_dig   = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign is_space = (ch_r == CH_SPACE) || ((ch_r >= CH_TAB) && (ch_r <= CH_CR));
  assign plen_inc = sat_inc(plen_r);

  always_comb begin
    mode_t  mode_m;
    logic   fin_err;
    mode_m   = mode_r;
    pst_nxt  = pst_r;
    plen_nxt = plen_r;
    pos_nxt  = pos_r;
    do_idle  = 1'b0;
    fin_err  = 1'b0;
    for (int i = 0; i < NCAND; i++) begin
      cand_en[i] = 1'b0;
      cand_k[i]  = TK_SEMI;
      cand_s[i]  = pos_r;
      cand_l[i]  = OFF_ONE;
    end

    case (mode_r)
      M_HALT: begin
      end
      M_NUM: begin
        if (is_dig) begin
          plen_nxt = plen_inc;
        end else begin
          cand_en[0] = 1'b1; cand_k[0] = TK_NUM;
          cand_s[0]  = pst_r; cand_l[0] = plen_r;
          do_idle    = 1'b1;
        end
      end
      M_DQ, M_SQ: begin
        plen_nxt = plen_inc;
        if (ch_r == ((mode_r == M_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
          cand_en[0] = 1'b1; cand_k[0] = TK_STR;
          cand_s[0]  = pst_r; cand_l[0] = plen_inc;
          mode_m     = M_IDLE;
        end
      end
      M_SLASH: begin
        if (ch_r == CH_SLASH) begin
          mode_m = M_LINE;
        end else if (ch_r == CH_STAR) begin
          plen_nxt = plen_inc;
          mode_m   = M_BLOCK;
        end else begin
          cand_en[0] = 1'b1; cand_k[0] = TK_MUL;
          cand_s[0]  = pst_r; cand_l[0] = OFF_ONE;
          do_idle    = 1'b1;
        end
      end
      M_LINE: begin
        if (ch_r == CH_LF || ch_r == CH_CR) mode_m = M_IDLE;
      end
      M_BLOCK, M_BSTAR: begin
        plen_nxt = plen_inc;
        if (ch_r == CH_STAR)                           mode_m = M_BSTAR;
        else if (mode_r == M_BSTAR && ch_r == CH_SLASH) mode_m = M_IDLE;
        else                                           mode_m = M_BLOCK;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // between tokens: single-byte tokens, or open a pending token
    if (do_idle) begin
      mode_m = M_IDLE;
      if (ch_r == CH_SEMI) begin
        cand_en[1] = 1'b1; cand_k[1] = TK_SEMI;
      end else if (is_space) begin
      end else if (is_dig || ch_r == CH_DQUOTE || ch_r == CH_SQUOTE
                   || ch_r == CH_SLASH) begin
        pst_nxt  = pos_r;
        plen_nxt = OFF_ONE;
        if (is_dig)                  mode_m = M_NUM;
        else if (ch_r == CH_DQUOTE)  mode_m = M_DQ;
        else if (ch_r == CH_SQUOTE)  mode_m = M_SQ;
        else                         mode_m = M_SLASH;
      end else if (ch_r == CH_LBRACE) begin
        cand_en[1] = 1'b1; cand_k[1] = TK_LBRACE;
      end else if (ch_r == CH_RBRACE) begin
        cand_en[1] = 1'b1; cand_k[1] = TK_RBRACE;
      end else if (ch_r == CH_PLUS || ch_r == CH_MINUS) begin
        cand_en[1] = 1'b1; cand_k[1] = TK_ADD;
      end else if (ch_r == CH_STAR) begin
        cand_en[1] = 1'b1; cand_k[1] = TK_MUL;
      end else if (ch_r == CH_LPAREN) begin
        cand_en[1] = 1'b1; cand_k[1] = TK_LPAREN;
      end else if (ch_r == CH_RPAREN) begin
        cand_en[1] = 1'b1; cand_k[1] = TK_RPAREN;
      end else begin
        cand_en[1] = 1'b1; cand_k[1] = TK_ERR;
        mode_m     = M_HALT;
      end
    end

    if (mode_r != M_HALT) pos_nxt = sat_inc(pos_r);
    mode_nxt = mode_m;

    // last byte: flush what is pending, then the end token unless the flush is an error
    if (fin_r && mode_m != M_HALT) begin
      cand_s[2] = pst_nxt;
      cand_l[2] = plen_nxt;
      case (mode_m)
        M_NUM: begin
          cand_en[2] = 1'b1; cand_k[2] = TK_NUM;
        end
        M_SLASH: begin
          cand_en[2] = 1'b1; cand_k[2] = TK_MUL; cand_l[2] = OFF_ONE;
        end
        M_DQ, M_SQ, M_BLOCK, M_BSTAR: begin
          cand_en[2] = 1'b1; cand_k[2] = TK_ERR;   // unterminated
          fin_err    = 1'b1;
        end
        default: begin
        end
      endcase
      if (!fin_err) begin
        cand_en[3] = 1'b1; cand_k[3] = TK_END;
        cand_s[3]  = pos_nxt; cand_l[3] = '0;
      end
      mode_nxt = M_HALT;
    end
  end

  // pack enabled candidates into result slots, in order
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int j = 0; j < NSLOT; j++) begin
      slot_k[j] = TK_SEMI;
      slot_s[j] = '0;
      slot_l[j] = '0;
    end
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && n != 2'd3) begin
        slot_k[n] = cand_k[i];
        slot_s[n] = cand_s[i];
        slot_l[n] = cand_l[i];
        n = n + 2'd1;
      end
    end
    res_n = n;
  end

  // ------------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= 1'b0;
      mode_r <= M_IDLE;
      pos_r  <= '0;
      pst_r  <= '0;
      plen_r <= '0;
      cnt_r  <= 2'd0;
      idx_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        inv_r <= 1'b1;
        ch_r  <= in_chan.char_code;
        fin_r <= in_chan.final_char;
      end else if (adv) begin
        inv_r <= 1'b0;
      end

      if (adv) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        pst_r  <= pst_nxt;
        plen_r <= plen_nxt;
        cnt_r  <= res_n;
        idx_r  <= 2'd0;
        for (int j = 0; j < NSLOT; j++) begin
          bk_r[j] <= slot_k[j];
          bs_r[j] <= slot_s[j];
          bl_r[j] <= slot_l[j];
        end
      end else if (out_fire) begin
        if (out_last) begin
          cnt_r <= 2'd0;
          idx_r <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------
  `EL_ASSERT_IMP(a_idx_in_batch, out_chan.valid, idx_r < cnt_r)
  `EL_ASSERT_IMP(a_halt_silent, adv && mode_r == M_HALT, res_n == 2'd0)
  `EL_ASSERT_NEXT(a_final_halts, adv && fin_r, mode_r == M_HALT)
  `EL_ASSERT_IMP(a_no_adv_while_busy, adv, cnt_r == 2'd0 || (out_fire && out_last))

endmodule

[tb/tb_expression_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_lexer
// Self-checking bench for the streaming expression lexer.
// ----------------------------------------------------------------------------
// One source text is streamed through the lexer after a single reset: a short
// hand-written opening, random well-formed lexemes with random content, one
// longer string, a few more lexemes, and one randomly chosen way of ending
// the text (clean end, open string, open comment or a bad byte followed by
// ignored bytes). A scoreboard predicts the tokens of every accepted byte and
// checks the token stream.
// ----------------------------------------------------------------------------
module tb_expression_lexer;
  import el_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;   // cycles with no request moving
  localparam int DRAIN_CYCLES    = 4000;
  localparam int TAIL_CYCLES     = 16;
  localparam int RANDOM_BYTES    = 90;
  localparam int LONG_BODY       = 20;

  localparam logic [FIELD_W-1:0] OFF_TOP  = '1;
  localparam logic [FIELD_W-1:0] LEN_ONE  = FIELD_W'(1);
  localparam logic [FIELD_W-1:0] LEN_ZERO = '0;

  // scanner state of the predictor
  typedef enum logic [3:0] {
    SM_IDLE, SM_NUM, SM_DQ, SM_SQ, SM_SLASH, SM_LINE, SM_BLOCK, SM_BSTAR, SM_HALT
  } scan_mode_t;

  // random lexeme shapes
  typedef enum int {
    LX_SEMI, LX_BLANK, LX_NUMBER, LX_DQ, LX_SQ, LX_LINE, LX_BLOCK,
    LX_LBRACE, LX_RBRACE, LX_ADD, LX_MUL, LX_DIV, LX_LPAREN, LX_RPAREN
  } lexeme_t;

  // ways the source text can end
  typedef enum int {
    END_NUM_PAREN, END_NUM, END_SLASH, END_LINE, END_SEMI,
    END_OPEN_STR, END_OPEN_CMT, END_BAD_BYTE
  } ending_t;

  typedef enum int { RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE } rx_style_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic               last;
  } token_t;

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // bytes that may open a lexeme; anything else is an error between tokens
  function automatic bit is_lead(logic [7:0] c);
    return is_blank(c) || is_digit(c) || c == ";" || c == "\"" || c == "'" ||
           c == "/" || c == "{" || c == "}" || c == "+" || c == "-" ||
           c == "*" || c == "(" || c == ")";
  endfunction

  // --------------------------------------------------------------------------
  // Token scoreboard: runs the scanner on each accepted byte and checks the
  // token stream against what it predicted, oldest first.
  // --------------------------------------------------------------------------
  class lexer_scoreboard_t;
    scan_mode_t         mode;
    logic [FIELD_W-1:0] next_pos;
    logic [FIELD_W-1:0] tok_start;
    logic [FIELD_W-1:0] tok_len;
    token_t             due_q[$];
    token_t             fresh_q[$];
    int                 bytes_seen;
    int                 tokens_checked;
    int                 errors;

    function new();
      mode      = SM_IDLE;
      next_pos  = '0;
      tok_start = '0;
      tok_len   = '0;
    endfunction

    function logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
      return (v == OFF_TOP) ? v : v + 1'b1;
    endfunction

    function void emit(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] start,
                       logic [FIELD_W-1:0] length);
      token_t t;
      t.kind   = kind;
      t.start  = start;
      t.length = length;
      t.last   = 1'b0;
      fresh_q.push_back(t);
    endfunction

    // byte seen with no token open
    function void between_tokens(logic [7:0] c, logic [FIELD_W-1:0] here);
      mode = SM_IDLE;
      if (c == ";") begin
        emit(TK_SEMI, here, LEN_ONE);
      end else if (is_blank(c)) begin
        return;
      end else if (is_digit(c) || c == "\"" || c == "'" || c == "/") begin
        tok_start = here;
        tok_len   = LEN_ONE;
        if (is_digit(c))    mode = SM_NUM;
        else if (c == "\"") mode = SM_DQ;
        else if (c == "'")  mode = SM_SQ;
        else                mode = SM_SLASH;
      end else begin
        case (c)
          "{":      emit(TK_LBRACE, here, LEN_ONE);
          "}":      emit(TK_RBRACE, here, LEN_ONE);
          "+", "-": emit(TK_ADD, here, LEN_ONE);
          "*":      emit(TK_MUL, here, LEN_ONE);
          "(":      emit(TK_LPAREN, here, LEN_ONE);
          ")":      emit(TK_RPAREN, here, LEN_ONE);
          default: begin
            mode = SM_HALT;
            emit(TK_ERR, here, LEN_ONE);
          end
        endcase
      end
    endfunction

    function void note_byte(logic [7:0] c, logic fin);
      logic [FIELD_W-1:0] here;
      token_t             t;
      here = next_pos;
      bytes_seen++;
      if (mode == SM_HALT) return;
      fresh_q.delete();
      case (mode)
        SM_NUM: begin
          if (is_digit(c)) begin
            tok_len = bump(tok_len);
          end else begin
            emit(TK_NUM, tok_start, tok_len);
            between_tokens(c, here);
          end
        end
        SM_DQ, SM_SQ: begin
          tok_len = bump(tok_len);
          if ((mode == SM_DQ && c == "\"") || (mode == SM_SQ && c == "'")) begin
            emit(TK_STR, tok_start, tok_len);
            mode = SM_IDLE;
          end
        end
        SM_SLASH: begin
          if (c == "/") begin
            mode = SM_LINE;
          end else if (c == "*") begin
            tok_len = bump(tok_len);
            mode    = SM_BLOCK;
          end else begin
            emit(TK_MUL, tok_start, LEN_ONE);
            between_tokens(c, here);
          end
        end
        SM_LINE: begin
          if (c == 8'h0A || c == 8'h0D) mode = SM_IDLE;
        end
        SM_BLOCK, SM_BSTAR: begin
          tok_len = bump(tok_len);
          if (c == "*")                          mode = SM_BSTAR;
          else if (mode == SM_BSTAR && c == "/") mode = SM_IDLE;
          else                                   mode = SM_BLOCK;
        end
        default: between_tokens(c, here);
      endcase
      next_pos = bump(next_pos);

      // last byte: flush what is open, then the end token unless it failed
      if (fin && mode != SM_HALT) begin
        case (mode)
          SM_NUM:   emit(TK_NUM, tok_start, tok_len);
          SM_SLASH: emit(TK_MUL, tok_start, LEN_ONE);
          SM_DQ, SM_SQ, SM_BLOCK, SM_BSTAR: begin
            emit(TK_ERR, tok_start, tok_len);
            mode = SM_HALT;
          end
          default: ;
        endcase
        if (mode != SM_HALT) emit(TK_END, next_pos, LEN_ZERO);
        mode = SM_HALT;
      end

      foreach (fresh_q[i]) begin
        t      = fresh_q[i];
        t.last = (i == fresh_q.size() - 1);
        due_q.push_back(t);
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (due_q.size() == 0) begin
        $error("token with none due: kind %0d start %0d length %0d",
               got.kind, got.start, got.length);
        errors++;
        return;
      end
      want = due_q.pop_front();
      tokens_checked++;
      if (got.kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.start !== want.start) begin
        $error("token_start: expected %0d, got %0d", want.start, got.start);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("token_length: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("run_last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  el_in_if  in_chan();
  el_out_if out_chan();

  expression_lexer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  lexer_scoreboard_t sb;
  logic [7:0]        src_q[$];      // whole source text; the sender raises the final flag on the last
  bit                last_was_div;  // a lone '/' must not fuse with what follows
  ending_t           ending;
  int                idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Source text builders
  // --------------------------------------------------------------------------
  function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == a || c == b) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic void add_digits(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) src_q.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  // quoted body without the closing quote
  function automatic void add_open_string(int hi);
    logic [7:0] q;
    int         n;
    q = $urandom_range(0, 1) ? "\"" : "'";
    n = $urandom_range(0, hi);
    src_q.push_back(q);
    repeat (n) src_q.push_back(any_but(q, q));
  endfunction

  // line comment body, never closed by CR or LF
  function automatic void add_open_line(int hi);
    int n;
    n = $urandom_range(0, hi);
    src_q.push_back("/");
    src_q.push_back("/");
    repeat (n) src_q.push_back(any_but(8'h0A, 8'h0D));
  endfunction

  // block comment body that never closes early; stars are frequent so the
  // star-then-slash tracking gets exercised
  function automatic void add_open_block(int hi);
    logic [7:0] c, prev;
    int         n;
    n    = $urandom_range(0, hi);
    prev = "/";
    src_q.push_back("/");
    src_q.push_back("*");
    repeat (n) begin
      c = ($urandom_range(0, 3) == 0) ? "*" : 8'($urandom_range(0, 255));
      if (prev == "*" && c == "/") c = "*";
      src_q.push_back(c);
      prev = c;
    end
  endfunction

  function automatic void add_lexeme();
    lexeme_t pick;
    pick = lexeme_t'($urandom_range(0, int'(LX_RPAREN)));
    if (last_was_div && (pick == LX_LINE || pick == LX_BLOCK ||
                         pick == LX_DIV || pick == LX_MUL))
      src_q.push_back(" ");
    case (pick)
      LX_SEMI:   src_q.push_back(";");
      LX_BLANK:  repeat ($urandom_range(1, 4)) src_q.push_back(pick_blank());
      LX_NUMBER: add_digits(1, 6);
      LX_DQ: begin
        src_q.push_back("\"");
        repeat ($urandom_range(0, 8)) src_q.push_back(any_but("\"", "\""));
        src_q.push_back("\"");
      end
      LX_SQ: begin
        src_q.push_back("'");
        repeat ($urandom_range(0, 8)) src_q.push_back(any_but("'", "'"));
        src_q.push_back("'");
      end
      LX_LINE: begin
        add_open_line(6);
        src_q.push_back($urandom_range(0, 1) ? 8'h0A : 8'h0D);
      end
      LX_BLOCK: begin
        add_open_block(6);
        if ($urandom_range(0, 1)) src_q.push_back("*");
        src_q.push_back("*");
        src_q.push_back("/");
      end
      LX_LBRACE: src_q.push_back("{");
      LX_RBRACE: src_q.push_back("}");
      LX_ADD:    src_q.push_back($urandom_range(0, 1) ? "+" : "-");
      LX_MUL:    src_q.push_back("*");
      LX_DIV:    src_q.push_back("/");
      LX_LPAREN: src_q.push_back("(");
      default:   src_q.push_back(")");
    endcase
    last_was_div = (pick == LX_DIV);
  endfunction

  // one way of ending the text per run; the seed decides which
  function automatic void add_ending();
    logic [7:0] c;
    if (last_was_div) src_q.push_back(" ");
    ending = ending_t'($urandom_range(0, int'(END_BAD_BYTE)));
    case (ending)
      END_NUM_PAREN: begin       // number flush, paren, end: three tokens
        add_digits(1, 3);
        src_q.push_back(")");
      end
      END_NUM:      add_digits(1, 3);
      END_SLASH:    src_q.push_back("/");
      END_LINE:     add_open_line(4);
      END_SEMI:     src_q.push_back(";");
      END_OPEN_STR: add_open_string(5);
      END_OPEN_CMT: begin
        add_open_block(5);
        if ($urandom_range(0, 1)) src_q.push_back("*");
      end
      default: begin             // bad byte, then bytes the lexer must ignore
        c = 8'($urandom_range(0, 255));
        while (is_lead(c)) c = 8'($urandom_range(0, 255));
        src_q.push_back(c);
        repeat ($urandom_range(0, 5)) src_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  function automatic void build_source();
    int opening;
    // opening: every token kind but error and end, all six blanks, byte extremes
    // inside a quote, an empty string, division followed by a number, a number
    // ended by a semicolon, and a block comment closed by a doubled star
    src_q = '{";", 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
              "'", 8'h00, 8'hFF, "'", "\"", "\"",
              "{", "}", "+", "-", "*", "(", ")",
              "/", "0", "9", ";", "/", "*", "*", "/"};
    last_was_div = 1'b0;
    opening = src_q.size();
    while (src_q.size() < opening + RANDOM_BYTES) add_lexeme();

    // one longer string with random content
    if (last_was_div) src_q.push_back(" ");
    src_q.push_back("\"");
    repeat (LONG_BODY) src_q.push_back(any_but("\"", "\""));
    src_q.push_back("\"");
    last_was_div = 1'b0;
    repeat (8) add_lexeme();
    add_ending();
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, sometimes none
  // --------------------------------------------------------------------------
  task automatic stream_source();
    int burst;
    int gap;
    while (src_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && src_q.size() > 0) begin
        in_chan.valid      <= 1'b1;
        in_chan.char_code  <= src_q[0];
        in_chan.final_char <= (src_q.size() == 1);
        @(posedge clk);
        while (!in_chan.ready) @(posedge clk);
        void'(src_q.pop_front());
        burst--;
      end
      if (gap > 0 && src_q.size() > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid      <= 1'b0;
    in_chan.final_char <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: the stall style is redrawn at random on rx_tick (always ready, coin
  // flip, fixed 5-of-8 comb, mostly stalled)
  // --------------------------------------------------------------------------
  logic [7:0] rx_tick  = '0;
  rx_style_t  rx_style = RX_OPEN;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick[5:0] == 6'd63) rx_style <= rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN: out_chan.ready <= 1'b1;
      RX_COIN: out_chan.ready <= 1'($urandom_range(0, 1));
      RX_COMB: out_chan.ready <= (rx_tick[2:0] < 3'd5);
      default: out_chan.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitors and watchdog; values read here are the ones before the edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    token_t got;
    if (rst_n && in_chan.valid && in_chan.ready)
      sb.note_byte(in_chan.char_code, in_chan.final_char);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.kind   = out_chan.token_kind;
      got.start  = out_chan.token_start;
      got.length = out_chan.token_length;
      got.last   = out_chan.run_last;
      sb.check_token(got);
    end
    if (!rst_n || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $error("no request moved for %0d cycles", WATCHDOG_CYCLES);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int drain;
    in_chan.valid      = 1'b0;
    in_chan.char_code  = '0;
    in_chan.final_char = 1'b0;
    rst_n              = 1'b0;
    sb = new();
    build_source();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    stream_source();

    // wait for every predicted token, then give the pipe time to show strays
    drain = 0;
    while (sb.due_q.size() > 0 && drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.due_q.size() > 0) begin
      $error("%0d predicted tokens never arrived", sb.due_q.size());
      sb.errors += sb.due_q.size();
    end

    $display("lexed %0d source bytes into %0d checked tokens under random stalls",
             sb.bytes_seen, sb.tokens_checked);
    $display("source ending this run: %s", ending.name());
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[expression_lexer.f]
+incdir+design
design/el_pkg.sv
design/el_in_if.sv
design/el_out_if.sv
design/expression_lexer.sv
tb/tb_expression_lexer.sv
